// ----- src/roet_pkg.sv -----
// Shared types and constants for the rectangle overlap eviction table.
`default_nettype none

package roet_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 64;
  localparam int unsigned FIELD_W         = 16;
  localparam int unsigned CNT_OUT_W       = 7;

  // Command codes on the kind field.
  localparam logic [1:0] KIND_APPEND = 2'd0;
  localparam logic [1:0] KIND_CLEAR  = 2'd1;
  localparam logic [1:0] KIND_DUMP   = 2'd2;

  typedef struct packed {
    logic signed [FIELD_W-1:0] x;
    logic signed [FIELD_W-1:0] y;
    logic signed [FIELD_W-1:0] w;
    logic signed [FIELD_W-1:0] h;
    logic        [FIELD_W-1:0] tag;
  } rect_t;

endpackage

`default_nettype wire

// ----- src/roet_hit.sv -----
// Strict overlap test between one stored rectangle and the new rectangle.
`default_nettype none

module roet_hit (
  input  roet_pkg::rect_t stored,
  input  roet_pkg::rect_t fresh,
  output logic            hit
);
  import roet_pkg::*;

  // Edges and far edges, widened by one bit so the sums never wrap.
  logic signed [FIELD_W:0] sx, sy, sxe, sye;
  logic signed [FIELD_W:0] nx, ny, nxe, nye;

  always_comb begin
    sx  = {stored.x[FIELD_W-1], stored.x};
    sy  = {stored.y[FIELD_W-1], stored.y};
    sxe = sx + $signed({stored.w[FIELD_W-1], stored.w});
    sye = sy + $signed({stored.h[FIELD_W-1], stored.h});
    nx  = {fresh.x[FIELD_W-1], fresh.x};
    ny  = {fresh.y[FIELD_W-1], fresh.y};
    nxe = nx + $signed({fresh.w[FIELD_W-1], fresh.w});
    nye = ny + $signed({fresh.h[FIELD_W-1], fresh.h});
    hit = (sx < nxe) && (sxe > nx) && (sy < nye) && (sye > ny);
  end

endmodule

`default_nettype wire

// ----- src/rect_overlap_evict_table.sv -----
// Top level: ordered rectangle table with overlap eviction, clear and dump.
`default_nettype none

// Command port: a transfer happens at a rising edge with start high and busy
// low; kind selects append (0), clear (1) or dump (2); kind 3 is ignored.
// Results leave on the out_* and count ports for one cycle under
// result_valid; the receiver cannot stall, so no result is ever held back.
// Entries live in a single-port-write, registered-read memory of
// MAX_ENTRIES x 80 bits; one overlap unit checks one stored entry per cycle.
// Append: the sequencer streams entries 0..N-1 (N = entries held) through
// the overlap unit, writing survivors back in order, then places the new
// entry if room is left (else dropped is set). busy stays high through the
// scan, its drain and the place step; the single result shows as busy falls.
// Clear: result in the next cycle, busy stays low.
// Dump: one result per cycle from the registered read; busy falls as the
// last result shows; an empty table gives one result with table_empty in
// the next cycle. last marks the final result of every command.
// Reset empties the table (the count clears; entry contents are left as is).

module rect_overlap_evict_table #(
  parameter int unsigned MAX_ENTRIES = roet_pkg::MAX_ENTRIES_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [1:0]                             kind,
  input  logic signed [roet_pkg::FIELD_W-1:0]    x_pos,
  input  logic signed [roet_pkg::FIELD_W-1:0]    y_pos,
  input  logic signed [roet_pkg::FIELD_W-1:0]    rect_width,
  input  logic signed [roet_pkg::FIELD_W-1:0]    rect_height,
  input  logic        [roet_pkg::FIELD_W-1:0]    text_tag,
  output logic                                   result_valid,
  output logic signed [roet_pkg::FIELD_W-1:0]    out_x,
  output logic signed [roet_pkg::FIELD_W-1:0]    out_y,
  output logic signed [roet_pkg::FIELD_W-1:0]    out_width,
  output logic signed [roet_pkg::FIELD_W-1:0]    out_height,
  output logic        [roet_pkg::FIELD_W-1:0]    out_tag,
  output logic        [roet_pkg::CNT_OUT_W-1:0]  entry_count,
  output logic        [roet_pkg::CNT_OUT_W-1:0]  evicted_count,
  output logic                                   dropped,
  output logic                                   last,
  output logic                                   table_empty
);
  import roet_pkg::*;

  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PLACE,
    ST_DUMP
  } state_t;

  state_t        state;
  logic [CW-1:0] count;     // entries held
  logic [CW-1:0] rd_idx;    // next entry to read
  logic [CW-1:0] keep;      // survivors written back so far
  logic          pend;      // rd_data holds entry rd_idx-1
  rect_t         new_rect;

  rect_t         mem [MAX_ENTRIES];
  rect_t         rd_data;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  rect_t         mem_wdata;

  logic          issue;
  logic          hit;
  logic          room;

  roet_hit u_hit (
    .stored (rd_data),
    .fresh  (new_rect),
    .hit    (hit)
  );

  assign busy  = (state != ST_IDLE);
  assign issue = (rd_idx < count);
  assign room  = (keep < CW'(MAX_ENTRIES));

  // Write port: survivors compact toward the front, then the new entry.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = keep[AW-1:0];
    mem_wdata = rd_data;
    case (state)
      ST_SCAN: begin
        mem_we = pend && !hit;
      end
      ST_PLACE: begin
        mem_we    = room;
        mem_wdata = new_rect;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Writes land at keep, which never passes the entry just read, so the
  // read ahead always sees the original contents.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[rd_idx[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      count        <= '0;
      rd_idx       <= '0;
      keep         <= '0;
      pend         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            new_rect <= '{x: x_pos, y: y_pos, w: rect_width, h: rect_height,
                          tag: text_tag};
            rd_idx   <= '0;
            keep     <= '0;
            pend     <= 1'b0;
            case (kind)
              KIND_APPEND: begin
                state <= ST_SCAN;
              end
              KIND_CLEAR: begin
                count         <= '0;
                result_valid  <= 1'b1;
                out_x         <= '0;
                out_y         <= '0;
                out_width     <= '0;
                out_height    <= '0;
                out_tag       <= '0;
                entry_count   <= '0;
                evicted_count <= '0;
                dropped       <= 1'b0;
                last          <= 1'b1;
                table_empty   <= 1'b0;
              end
              KIND_DUMP: begin
                if (count == '0) begin
                  result_valid  <= 1'b1;
                  out_x         <= '0;
                  out_y         <= '0;
                  out_width     <= '0;
                  out_height    <= '0;
                  out_tag       <= '0;
                  entry_count   <= '0;
                  evicted_count <= '0;
                  dropped       <= 1'b0;
                  last          <= 1'b1;
                  table_empty   <= 1'b1;
                end else begin
                  state <= ST_DUMP;
                end
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end

        ST_SCAN: begin
          if (issue) begin
            rd_idx <= rd_idx + 1'b1;
          end
          pend <= issue;
          if (pend && !hit) begin
            keep <= keep + 1'b1;
          end
          if (!issue && !pend) begin
            state <= ST_PLACE;
          end
        end

        ST_PLACE: begin
          count         <= room ? keep + 1'b1 : keep;
          result_valid  <= 1'b1;
          out_x         <= '0;
          out_y         <= '0;
          out_width     <= '0;
          out_height    <= '0;
          out_tag       <= '0;
          entry_count   <= CNT_OUT_W'(room ? keep + 1'b1 : keep);
          evicted_count <= CNT_OUT_W'(count - keep);
          dropped       <= !room;
          last          <= 1'b1;
          table_empty   <= 1'b0;
          state         <= ST_IDLE;
        end

        ST_DUMP: begin
          if (issue) begin
            rd_idx <= rd_idx + 1'b1;
          end
          pend <= issue;
          if (pend) begin
            result_valid  <= 1'b1;
            out_x         <= rd_data.x;
            out_y         <= rd_data.y;
            out_width     <= rd_data.w;
            out_height    <= rd_data.h;
            out_tag       <= rd_data.tag;
            entry_count   <= CNT_OUT_W'(count);
            evicted_count <= '0;
            dropped       <= 1'b0;
            last          <= (rd_idx == count);
            table_empty   <= 1'b0;
            if (rd_idx == count) begin
              state <= ST_IDLE;
            end
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
